// ===== hw/rtl/ftmgq_pkg.sv =====
package ftmgq_pkg;

    // Field widths of one transaction in each direction.
    localparam int HDR_W  = 24;
    localparam int BYTE_W = 8;

    // Input transaction: one linear channel value and the end-of-frame mark.
    typedef struct packed {
        logic [HDR_W-1:0] hdr_value;
        logic             last_in;
    } item_t;

    // Result transaction: one display byte and the end-of-frame mark.
    typedef struct packed {
        logic [BYTE_W-1:0] display_byte;
        logic              last_out;
    } result_t;

endpackage

// ===== hw/rtl/ftmgq_ram.sv =====
module ftmgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/ftmgq_gamma_init.sv =====
module ftmgq_gamma_init #(
    parameter int LUT_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    output logic                            ready,
    output logic                            wr_en,
    output logic [LUT_BITS-1:0]             wr_addr,
    output logic [ftmgq_pkg::BYTE_W-1:0]    wr_data
);

    // Entry k is the largest v with (2v-1)^11 * N^5 <= k^5 * 510^11.
    // Both sides are built by a limb-serial multiplier, one 32-bit limb per cycle.
    localparam int NUM_POW = 11;
    localparam int DEN_POW = 5;
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = (DEN_POW * LUT_BITS + 100 + LIMB_W - 1) / LIMB_W;
    localparam int WB      = LIMBS * LIMB_W;
    localparam int LIMB_CW = $clog2(LIMBS);
    localparam int MCW     = $clog2(NUM_POW);
    localparam int MW      = (LUT_BITS > 9) ? LUT_BITS : 9;
    localparam int PRW     = LIMB_W + MW;
    localparam int VW      = ftmgq_pkg::BYTE_W;

    localparam logic [LIMB_CW-1:0] LIMB_LAST = LIMB_CW'(LIMBS - 1);
    localparam logic [MCW-1:0]     NUM_LAST  = MCW'(NUM_POW - 1);
    localparam logic [MCW-1:0]     DEN_LAST  = MCW'(DEN_POW - 1);
    localparam logic [LUT_BITS-1:0] K_LAST   = {LUT_BITS{1'b1}};
    localparam logic [VW-1:0]      V_MAX     = {VW{1'b1}};

    // 510^11, the fixed factor of the right-hand side.
    function automatic logic [WB-1:0] gamma_scale();
        logic [WB-1:0] acc;
        acc = WB'(1);
        for (int i = 0; i < NUM_POW; i++)
        begin
            acc = acc * WB'(510);
        end
        return acc;
    endfunction

    localparam logic [WB-1:0] RHS_SEED = gamma_scale();
    localparam logic [WB-1:0] LHS_SEED = WB'(1) << (DEN_POW * LUT_BITS);

    typedef enum logic [3:0] {
        ST_LHS  = 4'b0001,
        ST_RHS  = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } init_state_t;

    init_state_t         state_reg, state_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [LUT_BITS-1:0] k_reg, k_next;
    logic [WB-1:0]       lhs_reg, lhs_next;
    logic [WB-1:0]       rhs_reg, rhs_next;
    logic [LIMB_CW-1:0]  limb_reg, limb_next;
    logic [MCW-1:0]      mul_reg, mul_next;
    logic [MW-1:0]       carry_reg, carry_next;

    logic [LIMB_W-1:0]   mul_src;
    logic [MW-1:0]       mul_m;
    logic [PRW-1:0]      prod;
    logic [MCW-1:0]      pow_last;

    // Shared limb multiplier: low limb of the operand times a small factor plus carry.
    always_comb
    begin
        if (state_reg == ST_LHS)
        begin
            mul_src  = lhs_reg[LIMB_W-1:0];
            mul_m    = MW'({v_reg, 1'b1});
            pow_last = NUM_LAST;
        end
        else
        begin
            mul_src  = rhs_reg[LIMB_W-1:0];
            mul_m    = MW'(k_reg);
            pow_last = DEN_LAST;
        end
        prod = PRW'(mul_src) * PRW'(mul_m) + PRW'(carry_reg);
    end

    // Sweep sequencer: walk k upward and raise v while the next level still fits.
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        limb_next  = limb_reg;
        mul_next   = mul_reg;
        carry_next = carry_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_LHS, ST_RHS:
            begin
                if (state_reg == ST_LHS)
                begin
                    lhs_next = {prod[LIMB_W-1:0], lhs_reg[WB-1:LIMB_W]};
                end
                else
                begin
                    rhs_next = {prod[LIMB_W-1:0], rhs_reg[WB-1:LIMB_W]};
                end
                carry_next = prod[PRW-1:LIMB_W];
                if (limb_reg == LIMB_LAST)
                begin
                    limb_next  = '0;
                    carry_next = '0;
                    if (mul_reg == pow_last)
                    begin
                        mul_next   = '0;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        mul_next = mul_reg + MCW'(1);
                    end
                end
                else
                begin
                    limb_next = limb_reg + LIMB_CW'(1);
                end
            end
            ST_CMP:
            begin
                if ((v_reg != V_MAX) && (lhs_reg <= rhs_reg))
                begin
                    v_next     = v_reg + VW'(1);
                    lhs_next   = LHS_SEED;
                    state_next = ST_LHS;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (k_reg == K_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + LUT_BITS'(1);
                        rhs_next   = RHS_SEED;
                        state_next = ST_RHS;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // The sweep starts on the first level against k = 0, whose right side is zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LHS;
            v_reg     <= '0;
            k_reg     <= '0;
            lhs_reg   <= LHS_SEED;
            rhs_reg   <= '0;
            limb_reg  <= '0;
            mul_reg   <= '0;
            carry_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            k_reg     <= k_next;
            lhs_reg   <= lhs_next;
            rhs_reg   <= rhs_next;
            limb_reg  <= limb_next;
            mul_reg   <= mul_next;
            carry_reg <= carry_next;
        end
    end

    assign ready   = (state_reg == ST_DONE);
    assign wr_addr = k_reg;
    assign wr_data = v_reg;

endmodule

// ===== hw/rtl/ftmgq_tone_pipe.sv =====
module ftmgq_tone_pipe #(
    parameter int LUT_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ftmgq_pkg::item_t      item,
    output logic                  out_valid,
    output logic                  out_last,
    output logic [LUT_BITS-1:0]   out_index
);

    localparam int RW  = ftmgq_pkg::HDR_W;
    localparam int CW  = FRAC_BITS + 2;
    localparam int PW  = CW + RW;
    localparam int XW  = PW + 1;
    localparam int XHW = XW - RW;
    localparam int LW  = 2 * RW;
    localparam int HW  = XHW + RW;
    localparam int VW  = FRAC_BITS + 52;

    // Curve coefficients rounded to FRAC_BITS fractional bits.
    localparam logic [CW-1:0] CA = CW'(((64'd251 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CW-1:0] CB = CW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CW-1:0] CC = CW'(((64'd243 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CW-1:0] CD = CW'(((64'd59 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CW-1:0] CE = CW'(((64'd14 << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic [XW-1:0] CB_SH = XW'(CB) << FRAC_BITS;
    localparam logic [XW-1:0] CD_SH = XW'(CD) << FRAC_BITS;
    localparam logic [VW-1:0] CE_SH = VW'(CE) << (2 * FRAC_BITS);

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg, s5_last_reg;
    logic [RW-1:0] s1_r_reg, s2_r_reg, s3_r_reg;
    logic [PW-1:0] s2_pa_reg, s2_pc_reg, s2_pa_next, s2_pc_next;
    logic [XW-1:0] s3_xa_reg, s3_xc_reg, s3_xa_next, s3_xc_next;
    logic [LW-1:0] s4_alo_reg, s4_dlo_reg, s4_alo_next, s4_dlo_next;
    logic [HW-1:0] s4_ahi_reg, s4_dhi_reg, s4_ahi_next, s4_dhi_next;
    logic [VW-1:0] s5_num_reg, s5_den_reg, s5_num_next, s5_den_next;

    // Division stages: entry 0 holds the prepared operands, entry i has i quotient bits.
    logic                 div_valid_reg [0:FRAC_BITS];
    logic                 div_last_reg  [0:FRAC_BITS];
    logic                 div_sat_reg   [0:FRAC_BITS];
    logic [VW-1:0]        div_rem_reg   [0:FRAC_BITS];
    logic [VW-1:0]        div_den_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] div_q_reg     [0:FRAC_BITS];

    logic                 sat_next;
    logic [FRAC_BITS-1:0] q_sat;

    // Front end arithmetic: inner products, offsets, outer products split at 24 bits.
    always_comb
    begin
        s2_pa_next  = PW'(s1_r_reg) * PW'(CA);
        s2_pc_next  = PW'(s1_r_reg) * PW'(CC);
        s3_xa_next  = XW'(s2_pa_reg) + CB_SH;
        s3_xc_next  = XW'(s2_pc_reg) + CD_SH;
        s4_alo_next = LW'(s3_xa_reg[RW-1:0]) * LW'(s3_r_reg);
        s4_dlo_next = LW'(s3_xc_reg[RW-1:0]) * LW'(s3_r_reg);
        s4_ahi_next = HW'(s3_xa_reg[XW-1:RW]) * HW'(s3_r_reg);
        s4_dhi_next = HW'(s3_xc_reg[XW-1:RW]) * HW'(s3_r_reg);
        s5_num_next = VW'(s4_alo_reg) + (VW'(s4_ahi_reg) << RW);
        s5_den_next = VW'(s4_dlo_reg) + (VW'(s4_dhi_reg) << RW) + CE_SH;
        sat_next    = (s5_num_reg >= s5_den_reg);
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            div_valid_reg[0] <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= in_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            div_valid_reg[0] <= s5_valid_reg;
        end
    end

    // Payload of the front stages. A quotient of one or more saturates, so its
    // remainder starts at zero and the final quotient is forced to all ones.
    always_ff @(posedge clk)
    begin
        s1_r_reg       <= item.hdr_value;
        s1_last_reg    <= item.last_in;
        s2_r_reg       <= s1_r_reg;
        s2_last_reg    <= s1_last_reg;
        s2_pa_reg      <= s2_pa_next;
        s2_pc_reg      <= s2_pc_next;
        s3_r_reg       <= s2_r_reg;
        s3_last_reg    <= s2_last_reg;
        s3_xa_reg      <= s3_xa_next;
        s3_xc_reg      <= s3_xc_next;
        s4_last_reg    <= s3_last_reg;
        s4_alo_reg     <= s4_alo_next;
        s4_dlo_reg     <= s4_dlo_next;
        s4_ahi_reg     <= s4_ahi_next;
        s4_dhi_reg     <= s4_dhi_next;
        s5_last_reg    <= s4_last_reg;
        s5_num_reg     <= s5_num_next;
        s5_den_reg     <= s5_den_next;
        div_last_reg[0] <= s5_last_reg;
        div_sat_reg[0]  <= sat_next;
        div_rem_reg[0]  <= sat_next ? '0 : s5_num_reg;
        div_den_reg[0]  <= s5_den_reg;
        div_q_reg[0]    <= '0;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 1; i <= FRAC_BITS; i++)
    begin : g_div
        logic [VW:0]          shifted;
        logic                 ge;
        logic [VW-1:0]        rem_next;
        logic [FRAC_BITS-1:0] q_next;

        always_comb
        begin
            shifted  = {div_rem_reg[i-1], 1'b0};
            ge       = (shifted >= {1'b0, div_den_reg[i-1]});
            rem_next = ge ? VW'(shifted - {1'b0, div_den_reg[i-1]}) : VW'(shifted);
            q_next   = {div_q_reg[i-1][FRAC_BITS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[i] <= 1'b0;
            end
            else
            begin
                div_valid_reg[i] <= div_valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            div_last_reg[i] <= div_last_reg[i-1];
            div_sat_reg[i]  <= div_sat_reg[i-1];
            div_rem_reg[i]  <= rem_next;
            div_den_reg[i]  <= div_den_reg[i-1];
            div_q_reg[i]    <= q_next;
        end
    end

    assign q_sat = div_sat_reg[FRAC_BITS] ? {FRAC_BITS{1'b1}} : div_q_reg[FRAC_BITS];

    // Table index from the top bits of the tone-mapped value.
    if (FRAC_BITS >= LUT_BITS)
    begin : g_idx_down
        assign out_index = q_sat[FRAC_BITS-1 -: LUT_BITS];
    end
    else
    begin : g_idx_up
        assign out_index = {q_sat, {(LUT_BITS - FRAC_BITS){1'b0}}};
    end

    assign out_valid = div_valid_reg[FRAC_BITS];
    assign out_last  = div_last_reg[FRAC_BITS];

endmodule

// ===== hw/rtl/filmic_tone_map_gamma_quantize_core.sv =====
// Filmic tone map with gamma quantization. After reset, busy stays high while the
// gamma table (2^LUT_BITS bytes) is built one entry at a time by a shared limb-serial
// multiplier working on ceil((5*LUT_BITS + 100) / 32) limbs of 32 bits. From then on
// busy is low for good and a transaction is taken on every clock that start is high.
// Each result appears on result with done high for exactly one cycle, in the order
// taken. The receiver cannot stall, so it must take every result as it comes.
// The pipeline holds an input register, four arithmetic stages and a saturation check
// in front of the divider, which resolves one quotient bit per stage, and the
// registered table read behind it.
module filmic_tone_map_gamma_quantize_core #(
    parameter int LUT_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ftmgq_pkg::item_t    item,
    output logic                done,
    output ftmgq_pkg::result_t  result
);

    localparam int DEPTH = 1 << LUT_BITS;

    logic                         table_ready;
    logic                         tbl_wr_en;
    logic [LUT_BITS-1:0]          tbl_wr_addr;
    logic [ftmgq_pkg::BYTE_W-1:0] tbl_wr_data;
    logic [ftmgq_pkg::BYTE_W-1:0] tbl_rd_data;

    logic                         pipe_valid;
    logic                         pipe_last;
    logic [LUT_BITS-1:0]          pipe_index;

    logic                         done_reg;
    logic                         last_reg;

    // Gamma table builder.
    ftmgq_gamma_init #(
        .LUT_BITS (LUT_BITS)
    ) u_gamma_init (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (table_ready),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    assign busy = !table_ready;

    // Tone curve and division pipeline.
    ftmgq_tone_pipe #(
        .LUT_BITS  (LUT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_tone_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .item      (item),
        .out_valid (pipe_valid),
        .out_last  (pipe_last),
        .out_index (pipe_index)
    );

    // Gamma table storage.
    ftmgq_ram #(
        .WIDTH (ftmgq_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_gamma_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (pipe_index),
        .rd_data (tbl_rd_data)
    );

    // Result strobe and frame mark line up with the registered table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= pipe_last;
    end

    assign done                = done_reg;
    assign result.display_byte = tbl_rd_data;
    assign result.last_out     = last_reg;

endmodule
